>>> sv/tlmlp_pkg.sv
// shared types and constants for the two-layer tanh perceptron evaluator
`timescale 1ns / 1ps

package tlmlp_pkg;

    localparam int DEF_IN_COUNT     = 8;
    localparam int DEF_HIDDEN_COUNT = 16;
    localparam int DEF_OUT_COUNT    = 3;

    localparam int ACC_W     = 40;
    localparam int MUL_W     = 20;
    localparam int DIV_STEPS = 14;

    localparam logic [18:0] TANH_K   = 19'd110592;
    localparam logic [39:0] SAT_MAG  = 40'd50331648;
    localparam logic [12:0] ONE_Q12  = 13'd4096;

    localparam logic CMD_PARAM  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BIAS_RD,
        ST_BIAS,
        ST_RD,
        ST_MAC,
        ST_TX,
        ST_TX2,
        ST_TNUM,
        ST_DIV_INIT,
        ST_DIV,
        ST_FIN,
        ST_EMIT
    } state_t;

endpackage

>>> sv/two_layer_tanh_mlp_eval_unit.sv
// two-layer perceptron evaluator with tanh activations on one shared mac unit
// Input channel (s_*): each transfer carries s_cmd. A parameter transfer (cmd 0)
// writes s_param_value at flat address s_param_index (W1, b1, W2, b2 in order;
// addresses past the store are dropped). A sample transfer (cmd 1) appends
// s_sample to the input vector. The sample that completes a vector starts the
// evaluation; s_ready stays low until the last result sits in the output register.
// Result channel (m_*): OUT_COUNT transfers per vector, m_channel counting up,
// m_last on the final one, m_level in unsigned Q1.12.
// Parameter and partial-vector transfers leave the unit idle and ready. A full
// vector's evaluation is set by the single multiplier that does every
// multiply-accumulate (each term passes a registered parameter memory read
// state, then a MAC state) and by the 14-step restoring divider of the tanh;
// a saturating unit skips the divider.
// A stalled receiver holds the result register; the sequencer waits before
// loading the next channel and resumes when the register frees.
// Reset (aresetn low, synchronous) clears the sequencer, the sample count and
// the result valid; parameter and buffer contents are kept and need writing.
`timescale 1ns / 1ps

module two_layer_tanh_mlp_eval_unit
    import tlmlp_pkg::*;
#(
    parameter int IN_COUNT     = DEF_IN_COUNT,
    parameter int HIDDEN_COUNT = DEF_HIDDEN_COUNT,
    parameter int OUT_COUNT    = DEF_OUT_COUNT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  logic [7:0]         s_param_index,
    input  logic signed [15:0] s_param_value,
    input  logic signed [15:0] s_sample,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_channel,
    output logic [12:0]        m_level,
    output logic               m_last
);

    localparam int B1_BASE   = HIDDEN_COUNT * IN_COUNT;
    localparam int W2_BASE   = B1_BASE + HIDDEN_COUNT;
    localparam int B2_BASE   = W2_BASE + OUT_COUNT * HIDDEN_COUNT;
    localparam int STORE_END = B2_BASE + OUT_COUNT;
    localparam int ADDR_W    = $clog2(STORE_END);
    localparam int CNT_W     = (IN_COUNT > 1) ? $clog2(IN_COUNT) : 1;
    localparam int HID_W     = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;
    localparam int MAX_UNIT  = (HIDDEN_COUNT > OUT_COUNT) ? HIDDEN_COUNT : OUT_COUNT;
    localparam int UNIT_W    = (MAX_UNIT > 1) ? $clog2(MAX_UNIT) : 1;
    localparam int MAX_TERM  = (HIDDEN_COUNT > IN_COUNT) ? HIDDEN_COUNT : IN_COUNT;
    localparam int TERM_W    = (MAX_TERM > 1) ? $clog2(MAX_TERM) : 1;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    state_t state_reg, state_next;

    logic signed [15:0] param_mem [STORE_END];
    logic signed [15:0] input_buf [IN_COUNT];
    logic signed [15:0] hidden_buf [HIDDEN_COUNT];

    logic [CNT_W-1:0]         cnt_reg;
    logic                     layer_reg;
    logic [UNIT_W-1:0]        unit_reg;
    logic [TERM_W-1:0]        term_reg;
    logic signed [15:0]       mem_rd_reg;
    logic signed [15:0]       act_rd_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     sign_reg;
    logic [13:0]              x_reg;
    logic [15:0]              x2_reg;
    logic [30:0]              num_reg;
    logic [18:0]              den_reg;
    logic [18:0]              rem_reg;
    logic [13:0]              quot_reg;
    logic [DCNT_W-1:0]        div_cnt_reg;
    logic [12:0]              mag_reg;
    logic                     m_valid_reg;
    logic [1:0]               m_channel_reg;
    logic [12:0]              m_level_reg;
    logic                     m_last_reg;

    logic                     in_xfer;
    logic                     wr_en;
    logic [31:0]              wr_wide;
    logic [31:0]              rd_wide;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [2*MUL_W-1:0] prod;
    logic [ACC_W-1:0]         mag_abs;
    logic                     sat;
    logic [19:0]              trial;
    logic [19:0]              trial_diff;
    logic [17:0]              kx2;
    logic signed [13:0]       t_val;
    logic signed [14:0]       lvl_sum;
    logic                     unit_hid_last;
    logic                     unit_out_last;
    logic                     term_last;
    logic                     out_free;

    assign in_xfer  = s_valid && s_ready;
    assign wr_wide  = 32'(s_param_index);
    assign wr_en    = in_xfer && (s_cmd == CMD_PARAM) && (wr_wide < 32'(STORE_END));
    assign out_free = !m_valid_reg || m_ready;

    assign unit_hid_last = (unit_reg == UNIT_W'(HIDDEN_COUNT - 1));
    assign unit_out_last = (unit_reg == UNIT_W'(OUT_COUNT - 1));
    assign term_last     = layer_reg ? (term_reg == TERM_W'(HIDDEN_COUNT - 1))
                                     : (term_reg == TERM_W'(IN_COUNT - 1));

    always_comb begin
        rd_wide = 32'd0;
        if (state_reg == ST_BIAS_RD) begin
            rd_wide = layer_reg ? (32'(B2_BASE) + 32'(unit_reg))
                                : (32'(B1_BASE) + 32'(unit_reg));
        end else begin
            rd_wide = layer_reg
                ? (32'(W2_BASE) + 32'(unit_reg) * 32'(HIDDEN_COUNT) + 32'(term_reg))
                : (32'(unit_reg) * 32'(IN_COUNT) + 32'(term_reg));
        end
    end

    // shared multiplier
    assign kx2 = 18'(TANH_K) + 18'(x2_reg);
    always_comb begin
        mul_a = MUL_W'(mem_rd_reg);
        mul_b = MUL_W'(act_rd_reg);
        if (state_reg == ST_TX2) begin
            mul_a = MUL_W'(x_reg);
            mul_b = MUL_W'(x_reg);
        end else if (state_reg == ST_TNUM) begin
            mul_a = MUL_W'(x_reg);
            mul_b = MUL_W'(kx2);
        end
    end
    assign prod = mul_a * mul_b;

    assign mag_abs    = acc_reg[ACC_W-1] ? (~acc_reg + 1'b1) : acc_reg;
    assign sat        = (mag_abs >= SAT_MAG);
    assign trial      = {rem_reg, num_reg[13]};
    assign trial_diff = trial - {1'b0, den_reg};
    assign t_val      = sign_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
    assign lvl_sum    = 15'(t_val) + 15'sd4096;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && (s_cmd == CMD_SAMPLE) && (cnt_reg == CNT_W'(IN_COUNT - 1))) begin
                    state_next = ST_BIAS_RD;
                end
            end
            ST_BIAS_RD:  state_next = ST_BIAS;
            ST_BIAS:     state_next = ST_RD;
            ST_RD:       state_next = ST_MAC;
            ST_MAC:      state_next = term_last ? ST_TX : ST_RD;
            ST_TX:       state_next = sat ? ST_FIN : ST_TX2;
            ST_TX2:      state_next = ST_TNUM;
            ST_TNUM:     state_next = ST_DIV_INIT;
            ST_DIV_INIT: state_next = ST_DIV;
            ST_DIV: begin
                if (div_cnt_reg == DCNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:      state_next = layer_reg ? ST_EMIT : ST_BIAS_RD;
            ST_EMIT: begin
                if (out_free) begin
                    state_next = unit_out_last ? ST_IDLE : ST_BIAS_RD;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // memories
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            param_mem[wr_wide[ADDR_W-1:0]] <= s_param_value;
        end
        if (in_xfer && (s_cmd == CMD_SAMPLE)) begin
            input_buf[cnt_reg] <= s_sample;
        end
        if ((state_reg == ST_FIN) && !layer_reg) begin
            hidden_buf[unit_reg[HID_W-1:0]] <= 16'(t_val);
        end
        mem_rd_reg <= param_mem[rd_wide[ADDR_W-1:0]];
        act_rd_reg <= layer_reg ? hidden_buf[term_reg[HID_W-1:0]]
                                : input_buf[term_reg[CNT_W-1:0]];
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_BIAS: begin
                acc_reg  <= {{(ACC_W-28){mem_rd_reg[15]}}, mem_rd_reg, 12'b0};
                term_reg <= '0;
            end
            ST_MAC: begin
                acc_reg <= acc_reg + ACC_W'(prod);
                if (!term_last) begin
                    term_reg <= term_reg + 1'b1;
                end
            end
            ST_TX: begin
                sign_reg <= acc_reg[ACC_W-1];
                x_reg    <= mag_abs[25:12];
                mag_reg  <= ONE_Q12;
            end
            ST_TX2: begin
                x2_reg <= prod[27:12];
            end
            ST_TNUM: begin
                num_reg <= prod[30:0];
                den_reg <= TANH_K + {x2_reg, 3'b0} + 19'(x2_reg);
            end
            ST_DIV_INIT: begin
                rem_reg     <= {2'b0, num_reg[30:14]};
                quot_reg    <= '0;
                div_cnt_reg <= '0;
            end
            ST_DIV: begin
                if (!trial_diff[19]) begin
                    rem_reg  <= trial_diff[18:0];
                    quot_reg <= {quot_reg[12:0], 1'b1};
                end else begin
                    rem_reg  <= trial[18:0];
                    quot_reg <= {quot_reg[12:0], 1'b0};
                end
                num_reg     <= {num_reg[29:0], 1'b0};
                div_cnt_reg <= div_cnt_reg + 1'b1;
                if (div_cnt_reg == DCNT_W'(DIV_STEPS - 1)) begin
                    mag_reg <= (quot_reg[12:0] >= 13'd2048 || quot_reg[13] || quot_reg[12])
                               && ({quot_reg[12:0], !trial_diff[19]} > 14'(ONE_Q12))
                               ? ONE_Q12 : {quot_reg[11:0], !trial_diff[19]};
                end
            end
            default: begin
            end
        endcase
    end

    // control counters and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            layer_reg   <= 1'b0;
            unit_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_xfer && (s_cmd == CMD_SAMPLE)) begin
                        if (cnt_reg == CNT_W'(IN_COUNT - 1)) begin
                            cnt_reg   <= '0;
                            layer_reg <= 1'b0;
                            unit_reg  <= '0;
                        end else begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                end
                ST_FIN: begin
                    if (!layer_reg) begin
                        if (unit_hid_last) begin
                            layer_reg <= 1'b1;
                            unit_reg  <= '0;
                        end else begin
                            unit_reg <= unit_reg + 1'b1;
                        end
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_valid_reg   <= 1'b1;
                        m_channel_reg <= 2'(unit_reg);
                        m_level_reg   <= lvl_sum[13:1];
                        m_last_reg    <= unit_out_last;
                        if (!unit_out_last) begin
                            unit_reg <= unit_reg + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_channel = m_channel_reg;
    assign m_level   = m_level_reg;
    assign m_last    = m_last_reg;

`ifndef SYNTH
    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == ST_IDLE))
        else $error("input taken outside idle");

    a_mag_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN) |-> (mag_reg <= ONE_Q12))
        else $error("tanh magnitude above one");

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_level <= ONE_Q12))
        else $error("level above one");

    a_emit_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && m_valid && !m_ready) |=> (state_reg == ST_EMIT))
        else $error("result register overwritten");
`endif

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the two-layer tanh perceptron evaluator
`timescale 1ns / 1ps

class mlp_scoreboard;
    int w1[128];
    int b1[16];
    int w2[48];
    int b2[3];
    int xin[8];
    int nsamp;
    bit [1:0] exp_channel[$];
    bit [12:0] exp_level[$];
    bit exp_last[$];
    int errors;
    int vectors;
    int results;

    function new();
        nsamp = 0;
        errors = 0;
        vectors = 0;
        results = 0;
    endfunction

    function int tanh_q12(longint z);
        longint m;
        longint x;
        longint x2;
        longint mag;
        m = (z < 0) ? -z : z;
        if (m >= (longint'(3) << 24)) begin
            mag = 4096;
        end else begin
            x = m >>> 12;
            x2 = (x * x) >>> 12;
            mag = (x * (110592 + x2)) / (110592 + 9 * x2);
            if (mag > 4096) mag = 4096;
        end
        return (z < 0) ? -int'(mag) : int'(mag);
    endfunction

    function void note_input(bit cmd, bit [7:0] idx, bit signed [15:0] pv,
                             bit signed [15:0] smp);
        longint acc;
        int hid[16];
        int t;
        if (cmd == tlmlp_pkg::CMD_PARAM) begin
            if (idx < 128) w1[idx] = pv;
            else if (idx < 144) b1[idx - 128] = pv;
            else if (idx < 192) w2[idx - 144] = pv;
            else if (idx < 195) b2[idx - 192] = pv;
            return;
        end
        xin[nsamp] = smp;
        nsamp++;
        if (nsamp < 8) return;
        nsamp = 0;
        vectors++;
        for (int j = 0; j < 16; j++) begin
            acc = longint'(b1[j]) * 4096;
            for (int i = 0; i < 8; i++) acc += longint'(w1[j * 8 + i]) * xin[i];
            hid[j] = tanh_q12(acc);
        end
        for (int k = 0; k < 3; k++) begin
            acc = longint'(b2[k]) * 4096;
            for (int j = 0; j < 16; j++) acc += longint'(w2[k * 16 + j]) * hid[j];
            t = tanh_q12(acc);
            exp_channel.push_back(k[1:0]);
            exp_level.push_back(13'((t + 4096) >> 1));
            exp_last.push_back(k == 2);
        end
    endfunction

    function void check_result(bit [1:0] ch, bit [12:0] lvl, bit lst);
        results++;
        if (exp_channel.size() == 0) begin
            $error("unexpected result channel=%0d level=%0d", ch, lvl);
            errors++;
            return;
        end
        if (exp_channel[0] != ch) begin
            $error("channel: expected %0d actual %0d", exp_channel[0], ch);
            errors++;
        end
        if (exp_level[0] != lvl) begin
            $error("level: expected %0d actual %0d", exp_level[0], lvl);
            errors++;
        end
        if (exp_last[0] != lst) begin
            $error("last: expected %0d actual %0d", exp_last[0], lst);
            errors++;
        end
        void'(exp_channel.pop_front());
        void'(exp_level.pop_front());
        void'(exp_last.pop_front());
    endfunction
endclass

module tb_top;
    import tlmlp_pkg::*;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_cmd;
    logic [7:0]         s_param_index;
    logic signed [15:0] s_param_value;
    logic signed [15:0] s_sample;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_channel;
    logic [12:0]        m_level;
    logic               m_last;

    mlp_scoreboard sb;
    bit rx_hold;
    int hold_len;

    two_layer_tanh_mlp_eval_unit u_dut (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #400_000;
        $display("** two_layer_tanh_mlp_eval_unit: FAILED **");
        $finish;
    end

    // valid stays high into the next item when no gap is drawn
    task automatic send_item(bit cmd, bit [7:0] idx, bit [15:0] pv, bit [15:0] smp);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_param_index <= idx;
        s_param_value <= pv;
        s_sample <= smp;
        do @(posedge aclk); while (!(s_valid && s_ready));
        sb.note_input(cmd, idx, pv, smp);
        @(negedge aclk);
    endtask

    // all words written so no unwritten read occurs
    task automatic load_params(int mode);
        bit [15:0] v;
        for (int a = 0; a < 195; a++) begin
            case (mode)
                0: v = 16'h7fff;
                1: v = 16'h8000;
                2: v = 16'(int'($urandom_range(0, 2047)) - 1024);
                default: v = 16'($urandom);
            endcase
            send_item(CMD_PARAM, a[7:0], v, 16'($urandom));
        end
    endtask

    task automatic send_vector(int mode);
        bit [15:0] v;
        for (int i = 0; i < 8; i++) begin
            case (mode)
                0: v = 16'h7fff;
                1: v = 16'h8000;
                2: v = 16'h0000;
                3: v = 16'(int'($urandom_range(0, 4095)) - 2048);
                default: v = 16'($urandom);
            endcase
            send_item(CMD_SAMPLE, 8'($urandom), 16'($urandom), v);
        end
    endtask

    // receiver with random stalls and one long hold-off
    initial begin
        int w;
        bit held;
        held = 1'b0;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (rx_hold && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (hold_len) @(negedge aclk);
            end
            w = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 14);
            if (w > 0) begin
                m_ready <= 1'b0;
                repeat (w) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            sb.check_result(m_channel, m_level, m_last);
        end
    end

    initial begin
        int n;
        sb = new();
        s_valid = 1'b0;
        s_cmd = CMD_PARAM;
        s_param_index = '0;
        s_param_value = '0;
        s_sample = '0;
        aresetn = 1'b0;
        rx_hold = 1'b0;
        hold_len = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: one full parameter load, extreme and zero samples
        load_params(2);
        send_vector(0);
        send_vector(1);
        send_vector(2);
        send_item(CMD_PARAM, 8'd195, 16'h1234, 16'h0);
        send_item(CMD_PARAM, 8'hff, 16'h8000, 16'hffff);
        // long receiver hold-off while vectors queue up
        hold_len = 3000;
        rx_hold = 1'b1;
        send_vector(3);
        send_vector(3);
        send_vector(4);

        n = 0;
        while (n < 30) begin
            if ($urandom_range(0, 3) == 0) begin
                send_item(CMD_PARAM, 8'($urandom_range(0, 255)), 16'($urandom),
                          16'($urandom));
                n++;
            end else begin
                send_vector($urandom_range(3, 4));
                n += 8;
            end
        end
        // an interleaved parameter write partway through a vector
        for (int i = 0; i < 8; i++) begin
            send_item(CMD_SAMPLE, 8'($urandom), 16'($urandom), 16'($urandom));
            if (i == 3) send_item(CMD_PARAM, 8'($urandom_range(0, 194)), 16'($urandom),
                                  16'h0);
        end
        s_valid <= 1'b0;

        n = 0;
        while (sb.exp_channel.size() != 0 && n < 20000) begin
            @(posedge aclk);
            n++;
        end
        repeat (1000) @(posedge aclk);
        $display("vectors evaluated: %0d, results checked: %0d", sb.vectors, sb.results);
        if (sb.errors == 0 && sb.exp_channel.size() == 0) begin
            $display("** two_layer_tanh_mlp_eval_unit: PASSED **");
        end else begin
            $display("** two_layer_tanh_mlp_eval_unit: FAILED **");
        end
        $finish;
    end
endmodule
